// ----- sv/rbd_pkg.sv -----
// shared types and constants for the ring buffer deque
package rbd_pkg;

    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        MODE_ADD_FRONT  = 2'd0,
        MODE_TAKE_FRONT = 2'd1,
        MODE_ADD_BACK   = 2'd2,
        MODE_TAKE_BACK  = 2'd3
    } mode_t;

    // accepted operation waiting for its result to be formed; pops also wait on their memory read
    typedef struct packed {
        logic                      is_pop;
        logic                      empty;
        logic                      dropped;
        logic signed [FIELD_W-1:0] expected;
    } pend_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == IDX_LAST) ? '0 : i + IDX_W'(1);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == '0) ? IDX_LAST : i - IDX_W'(1);
        return r;
    endfunction

endpackage

// ----- sv/rbd_intf.sv -----
// request and response channel interfaces of the ring buffer deque
interface rbd_req_if import rbd_pkg::*;;
    logic                      valid;
    logic                      ready;
    mode_t                     mode;
    logic signed [FIELD_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface rbd_rsp_if import rbd_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] popped_value;
    logic                      was_empty;
    logic                      push_dropped;
    logic                      expected_matched;
    logic                      all_matched;

    modport source (
        output valid, output popped_value, output was_empty, output push_dropped,
        output expected_matched, output all_matched, input ready
    );
    modport sink (
        input valid, input popped_value, input was_empty, input push_dropped,
        input expected_matched, input all_matched, output ready
    );
endinterface

// ----- sv/rbd_ram.sv -----
// simple dual port ram with registered read data
module rbd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/ring_buffer_deque.sv -----
// ring buffer deque top level: index control, result stage and element memory
//
// Double-ended queue of CAPACITY elements in a circular memory. Each request
// transfer is one operation (push or pop at either end) and yields exactly one
// response transfer. Indices and count are updated when the request is taken,
// and the memory read for a pop is issued in that same cycle; the result is
// formed from the registered read data when the output register can take it
// and lands there. One operation per cycle is sustained as long as responses
// are taken. The element memory needs no initialization after reset: a pop
// only reads entries that an earlier push wrote.
module ring_buffer_deque import rbd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    rbd_req_if.sink   req,
    rbd_rsp_if.source rsp
);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             mismatch_reg, mismatch_next;

    logic             pend_valid_reg, pend_valid_next;
    pend_t            pend_reg, pend_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [FIELD_W-1:0] out_value_reg, out_value_next;
    logic                      out_empty_reg, out_empty_next;
    logic                      out_dropped_reg, out_dropped_next;
    logic                      out_matched_reg, out_matched_next;
    logic                      out_all_reg, out_all_next;

    logic                  accept;
    logic                  pend_move;
    logic                  is_empty;
    logic                  is_full;
    logic                  mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;
    logic [63:0]           push_wide;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [63:0]           pop_wide;
    logic signed [FIELD_W-1:0] popped;
    logic                  matched;

    assign pend_move = pend_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !pend_valid_reg || pend_move;
    assign accept    = req.valid && req.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_FULL);

    // pushed data keeps its low bits, zero above the field
    assign push_wide = {32'b0, req.value};
    assign mem_wdata = push_wide[DATA_WIDTH-1:0];

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = front_reg;
        mem_raddr  = back_reg;
        pend_next  = pend_reg;
        if (accept)
        begin
            pend_next.is_pop   = (req.mode == MODE_TAKE_FRONT) || (req.mode == MODE_TAKE_BACK);
            pend_next.empty    = 1'b0;
            pend_next.dropped  = 1'b0;
            pend_next.expected = req.value;
            case (req.mode)
                MODE_ADD_FRONT:
                begin
                    if (is_full)
                    begin
                        pend_next.dropped = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = front_reg;
                        front_next = idx_inc(front_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_ADD_BACK:
                begin
                    if (is_full)
                    begin
                        pend_next.dropped = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = idx_dec(back_reg);
                        back_next  = idx_dec(back_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_TAKE_FRONT:
                begin
                    if (is_empty)
                    begin
                        pend_next.empty = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_dec(front_reg);
                        front_next = idx_dec(front_reg);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_TAKE_BACK:
                begin
                    if (is_empty)
                    begin
                        pend_next.empty = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = back_reg;
                        back_next  = idx_inc(back_reg);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    pend_next.is_pop = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
    end

    // sign-extend from the stored width, then cut to the field
    assign pop_wide = 64'(signed'(mem_rdata));

    always_comb
    begin
        if (!pend_reg.is_pop)
        begin
            popped = '0;
        end
        else if (pend_reg.empty)
        begin
            popped = '1;
        end
        else
        begin
            popped = pop_wide[FIELD_W-1:0];
        end
        matched = pend_reg.is_pop && (popped == pend_reg.expected);
    end

    always_comb
    begin
        mismatch_next    = mismatch_reg;
        out_value_next   = out_value_reg;
        out_empty_next   = out_empty_reg;
        out_dropped_next = out_dropped_reg;
        out_matched_next = out_matched_reg;
        out_all_next     = out_all_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        if (pend_move)
        begin
            if (pend_reg.is_pop && !matched)
            begin
                mismatch_next = 1'b1;
            end
            out_valid_next   = 1'b1;
            out_value_next   = popped;
            out_empty_next   = pend_reg.empty;
            out_dropped_next = pend_reg.dropped;
            out_matched_next = matched;
            out_all_next     = !(mismatch_reg || (pend_reg.is_pop && !matched));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            back_reg       <= '0;
            count_reg      <= '0;
            mismatch_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            front_reg      <= front_next;
            back_reg       <= back_next;
            count_reg      <= count_next;
            mismatch_reg   <= mismatch_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg        <= pend_next;
        out_value_reg   <= out_value_next;
        out_empty_reg   <= out_empty_next;
        out_dropped_reg <= out_dropped_next;
        out_matched_reg <= out_matched_next;
        out_all_reg     <= out_all_next;
    end

    rbd_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rsp.valid            = out_valid_reg;
    assign rsp.popped_value     = out_value_reg;
    assign rsp.was_empty        = out_empty_reg;
    assign rsp.push_dropped     = out_dropped_reg;
    assign rsp.expected_matched = out_matched_reg;
    assign rsp.all_matched      = out_all_reg;

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the ring buffer deque
module tb_top;
    import rbd_pkg::*;

    typedef struct {
        mode_t               mode;
        logic [FIELD_W-1:0]  value;
    } deque_op_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  popped;
        logic                empty;
        logic                dropped;
        logic                matched;
        logic                all_ok;
    } deque_result_t;

    logic clk;
    logic rst_n;

    rbd_req_if req_ch ();
    rbd_rsp_if rsp_ch ();

    ring_buffer_deque dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deque_op_t     pending_ops[$];
    deque_result_t expected_results[$];
    logic [FIELD_W-1:0] shadow_contents[$];

    // mirror of the deque as the block should hold it
    logic [DATA_WIDTH-1:0] mirror_store [CAPACITY];
    int  front_ptr     = 0;
    int  back_ptr      = 0;
    int  held_count    = 0;
    bit  mismatch_flag = 1'b0;

    int  error_count    = 0;
    int  accepted_ops   = 0;
    int  responses_seen = 0;
    int  total_ops      = 0;
    int  send_gap       = 0;
    int  recv_stall     = 0;
    logic hold_ready    = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic deque_result_t predict_deque_op(mode_t m, logic [FIELD_W-1:0] v);
        deque_result_t r;
        r = '0;
        if (m == MODE_ADD_FRONT || m == MODE_ADD_BACK)
        begin
            if (held_count == CAPACITY)
                r.dropped = 1'b1;
            else if (m == MODE_ADD_FRONT)
            begin
                mirror_store[front_ptr] = v[DATA_WIDTH-1:0];
                front_ptr = (front_ptr == CAPACITY - 1) ? 0 : front_ptr + 1;
                held_count++;
            end
            else
            begin
                back_ptr = (back_ptr == 0) ? CAPACITY - 1 : back_ptr - 1;
                mirror_store[back_ptr] = v[DATA_WIDTH-1:0];
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                r.empty  = 1'b1;
                r.popped = '1;
            end
            else if (m == MODE_TAKE_FRONT)
            begin
                front_ptr = (front_ptr == 0) ? CAPACITY - 1 : front_ptr - 1;
                r.popped = FIELD_W'($signed(mirror_store[front_ptr]));
                held_count--;
            end
            else
            begin
                r.popped = FIELD_W'($signed(mirror_store[back_ptr]));
                back_ptr = (back_ptr == CAPACITY - 1) ? 0 : back_ptr + 1;
                held_count--;
            end
            r.matched = (r.popped == v);
            if (!r.matched)
                mismatch_flag = 1'b1;
        end
        r.all_ok = !mismatch_flag;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                   logic [FIELD_W-1:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch on response %0d, %s: got %0h, want %0h",
                     responses_seen, what, got, want);
    endtask

    // mostly short gaps, a few long ones, and stretches with none at all
    function automatic int pick_gap(int n);
        int r;
        if ((n / 128) % 4 == 2)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(FIELD_W-1){1'b0}}};
            1: return {1'b0, {(FIELD_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // queue one operation; pops carry what the deque should return unless spoiled
    task automatic add_op(mode_t m, logic [FIELD_W-1:0] push_val, bit spoil);
        deque_op_t op;
        logic [FIELD_W-1:0] want;
        op.mode = m;
        if (m == MODE_ADD_FRONT || m == MODE_ADD_BACK)
        begin
            op.value = push_val;
            if (shadow_contents.size() < CAPACITY)
            begin
                if (m == MODE_ADD_FRONT)
                    shadow_contents.insert(0, push_val);
                else
                    shadow_contents.insert(shadow_contents.size(), push_val);
            end
        end
        else
        begin
            if (shadow_contents.size() == 0)
                want = '1;
            else if (m == MODE_TAKE_FRONT)
            begin
                want = shadow_contents[0];
                shadow_contents.delete(0);
            end
            else
            begin
                want = shadow_contents[shadow_contents.size() - 1];
                shadow_contents.delete(shadow_contents.size() - 1);
            end
            if (spoil)
                want = want ^ (FIELD_W'($urandom) | FIELD_W'(1));
            op.value = want;
        end
        pending_ops.insert(pending_ops.size(), op);
        total_ops++;
    endtask

    // request driver
    always @(posedge clk)
    begin
        deque_op_t nxt;
        deque_result_t res;
        logic fire;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            fire = req_ch.valid && req_ch.ready;
            if (fire)
            begin
                res = predict_deque_op(req_ch.mode, req_ch.value);
                expected_results.insert(expected_results.size(), res);
                accepted_ops++;
                send_gap = pick_gap(accepted_ops);
            end
            if (!req_ch.valid || fire)
            begin
                if (send_gap == 0 && pending_ops.size() != 0)
                begin
                    nxt = pending_ops[0];
                    pending_ops.delete(0);
                    req_ch.valid <= 1'b1;
                    req_ch.mode  <= nxt.mode;
                    req_ch.value <= nxt.value;
                end
                else
                begin
                    if (send_gap > 0)
                        send_gap--;
                    req_ch.valid <= 1'b0;
                    req_ch.mode  <= mode_t'(2'($urandom_range(0, 3)));
                    req_ch.value <= FIELD_W'($urandom);
                end
            end
        end
    end

    // response monitor and ready control
    always @(posedge clk)
    begin
        deque_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                responses_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("response with nothing outstanding",
                                    rsp_ch.popped_value, '0);
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (rsp_ch.popped_value !== want.popped)
                        report_mismatch("popped_value", rsp_ch.popped_value, want.popped);
                    if (rsp_ch.was_empty !== want.empty)
                        report_mismatch("was_empty", FIELD_W'(rsp_ch.was_empty),
                                        FIELD_W'(want.empty));
                    if (rsp_ch.push_dropped !== want.dropped)
                        report_mismatch("push_dropped", FIELD_W'(rsp_ch.push_dropped),
                                        FIELD_W'(want.dropped));
                    if (rsp_ch.expected_matched !== want.matched)
                        report_mismatch("expected_matched",
                                        FIELD_W'(rsp_ch.expected_matched),
                                        FIELD_W'(want.matched));
                    if (rsp_ch.all_matched !== want.all_ok)
                        report_mismatch("all_matched", FIELD_W'(rsp_ch.all_matched),
                                        FIELD_W'(want.all_ok));
                end
                recv_stall = pick_gap(responses_seen + 64);
            end
            if (hold_ready)
                rsp_ch.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // one long receiver hold-off while the deque is being filled
    initial
    begin
        while (responses_seen < 600)
            @(negedge clk);
        @(posedge clk);
        hold_ready <= 1'b1;
        repeat (400) @(posedge clk);
        hold_ready <= 1'b0;
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int stage;
        int rand_count;
        int stage_count;
        int drops;
        bit is_push;
        bit at_full;
        mode_t m;

        req_ch.valid = 1'b0;
        req_ch.mode  = MODE_ADD_FRONT;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        rst_n = 1'b0;
        clk = 1'b0;

        // directed: empty pops, extremes, both index wraps, lifo at each end
        add_op(MODE_TAKE_FRONT, '0, 1'b0);
        add_op(MODE_TAKE_BACK, '0, 1'b0);
        add_op(MODE_ADD_BACK, 32'h7fff_ffff, 1'b0);
        add_op(MODE_ADD_BACK, 32'h8000_0000, 1'b0);
        add_op(MODE_ADD_FRONT, 32'h0000_0000, 1'b0);
        add_op(MODE_ADD_FRONT, 32'hffff_ffff, 1'b0);
        add_op(MODE_TAKE_FRONT, '0, 1'b0);
        add_op(MODE_TAKE_FRONT, '0, 1'b0);
        add_op(MODE_TAKE_FRONT, '0, 1'b0);
        add_op(MODE_TAKE_BACK, '0, 1'b0);
        add_op(MODE_TAKE_BACK, '0, 1'b0);
        add_op(MODE_ADD_FRONT, 32'h5555_5555, 1'b0);
        add_op(MODE_ADD_FRONT, 32'haaaa_aaaa, 1'b0);
        add_op(MODE_TAKE_BACK, '0, 1'b0);
        add_op(MODE_TAKE_BACK, '0, 1'b0);
        add_op(MODE_ADD_BACK, 32'h0000_0001, 1'b0);
        add_op(MODE_ADD_FRONT, 32'hfedc_ba98, 1'b0);
        add_op(MODE_TAKE_BACK, '0, 1'b0);
        add_op(MODE_TAKE_FRONT, '0, 1'b0);
        add_op(MODE_TAKE_FRONT, '0, 1'b0);
        add_op(MODE_ADD_BACK, 32'hffff_ffff, 1'b0);
        add_op(MODE_TAKE_BACK, '0, 1'b0);

        // random: balanced traffic, then fill to full with drops, then drain
        stage = 0;
        rand_count = 0;
        stage_count = 0;
        drops = 0;
        while (!(stage == 2 && rand_count >= 1620))
        begin
            at_full = (shadow_contents.size() == CAPACITY);
            case (stage)
                0: is_push = ($urandom_range(0, 1) == 1);
                1: is_push = ($urandom_range(0, 99) < (at_full ? 60 : 95));
                default: is_push = ($urandom_range(0, 99) < 20);
            endcase
            if (is_push)
                m = ($urandom_range(0, 1) == 1) ? MODE_ADD_FRONT : MODE_ADD_BACK;
            else
                m = ($urandom_range(0, 1) == 1) ? MODE_TAKE_FRONT : MODE_TAKE_BACK;
            if (is_push && at_full)
                drops++;
            // mismatches are sticky, so they only appear late in the drain
            add_op(m, rand_word(),
                   stage == 2 && stage_count >= 60 && $urandom_range(0, 49) == 0);
            rand_count++;
            stage_count++;
            if (stage == 0 && rand_count >= 250)
            begin
                stage = 1;
                stage_count = 0;
            end
            else if (stage == 1 && drops >= 8)
            begin
                stage = 2;
                stage_count = 0;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_ops < total_ops)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/rbd_pkg.sv
sv/rbd_intf.sv
sv/rbd_ram.sv
sv/ring_buffer_deque.sv
dv/tb_top.sv
